FILE: sv/tvcs_pkg.sv
`timescale 1ns / 1ps

package tvcs_pkg;

    // Build-time settings
    localparam int FRAC_BITS     = 8;
    localparam int CORDIC_STAGES = 16;
    localparam int COORD_BITS    = 15;

    // Field widths
    localparam int MODE_W = 3;
    localparam int AMT_W  = 21;
    localparam int COL_W  = 4;
    localparam int BG_W   = 3;
    localparam int CHAR_W = 8;
    localparam int STAT_W = 3;

    localparam int S_PAY_W  = AMT_W + COL_W + CHAR_W;
    localparam int S_DATA_W = ((S_PAY_W + 7) / 8) * 8;
    localparam int M_PAY_W  = 4 * COORD_BITS + CHAR_W + COL_W + BG_W;
    localparam int M_DATA_W = ((M_PAY_W + 7) / 8) * 8;

    // Heading: unsigned degrees with FRAC_BITS fraction bits, kept in [0, 360)
    localparam int FULL_TURN = 360 << FRAC_BITS;
    localparam int QUARTER   = 90 << FRAC_BITS;
    localparam int HEAD_W    = $clog2(FULL_TURN);

    // amount mod 360: offset amount to a positive value, then divide by
    // 45 * 2^(FRAC_BITS+3) as a shift plus a reciprocal multiply
    localparam int TURN_K      = ((1 << (AMT_W - 1)) + FULL_TURN - 1) / FULL_TURN;
    localparam int TURN_OFFSET = TURN_K * FULL_TURN;
    localparam int U_W         = $clog2((1 << (AMT_W - 1)) + TURN_OFFSET);
    localparam int V_SH        = FRAC_BITS + 3;
    localparam int V_W         = U_W - V_SH;
    localparam int RSH         = V_W + 6;
    localparam int RECIP       = ((1 << RSH) + 44) / 45;
    localparam int RECIP_W     = $clog2(RECIP + 1);
    localparam int Q_W         = V_W - 5;

    // CORDIC formats
    localparam int ANG_FRAC  = 16;
    localparam int ZSH       = ANG_FRAC - FRAC_BITS;
    localparam int TABLE_LEN = 24;
    localparam int IDX_W     = $clog2(TABLE_LEN);
    localparam int Z_W       = 24;
    localparam int XY_W      = 32;
    localparam int CS_FRAC   = 30;
    localparam logic signed [XY_W-1:0] CORDIC_GAIN = 32'sd652032874;

    // Displacement and position
    localparam int PROD_W   = AMT_W + XY_W;
    localparam int DX_W     = AMT_W + 1;
    localparam int POS_W    = COORD_BITS + FRAC_BITS + 1;
    localparam int NX_W     = POS_W + 2;
    localparam int COORD_HI = FRAC_BITS + COORD_BITS;

    localparam logic signed [PROD_W:0] HALF_Q30 = (PROD_W + 1)'(64'sd1 <<< (CS_FRAC - 1));
    localparam logic signed [NX_W-1:0] HALF_PIX = NX_W'(1 << (FRAC_BITS - 1));

    // Command codes
    localparam logic [MODE_W-1:0] MODE_ROTATE  = 3'd0;
    localparam logic [MODE_W-1:0] MODE_MOVE    = 3'd1;
    localparam logic [MODE_W-1:0] MODE_DRAW    = 3'd2;
    localparam logic [MODE_W-1:0] MODE_FG      = 3'd3;
    localparam logic [MODE_W-1:0] MODE_BG      = 3'd4;
    localparam logic [MODE_W-1:0] MODE_PATTERN = 3'd5;

    localparam logic [CHAR_W-1:0] CHAR_SPACE    = 8'd32;
    localparam logic [CHAR_W-1:0] RESET_PATTERN = 8'd43;
    localparam logic [COL_W-1:0]  RESET_FG      = 4'd7;
    localparam logic [BG_W-1:0]   RESET_BG      = 3'd0;

    typedef enum logic [STAT_W-1:0] {
        ST_UPDATED    = 3'd0,
        ST_SEGMENT    = 3'd1,
        ST_OFF_RANGE  = 3'd2,
        ST_BAD_LENGTH = 3'd3,
        ST_BAD_COLOUR = 3'd4
    } status_t;

    typedef struct packed {
        logic [MODE_W-1:0]       mode;
        logic signed [AMT_W-1:0] amount;
        logic [COL_W-1:0]        colour;
        logic [CHAR_W-1:0]       pchar;
        logic [1:0]              quad;
    } cmd_t;

    typedef struct packed {
        logic                   valid;
        cmd_t                   cmd;
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [Z_W-1:0]  z;
    } stage_t;

    typedef struct packed {
        status_t                status;
        logic [COORD_BITS-1:0]  sx;
        logic [COORD_BITS-1:0]  sy;
        logic [COORD_BITS-1:0]  ex;
        logic [COORD_BITS-1:0]  ey;
        logic [CHAR_W-1:0]      pchar;
        logic [COL_W-1:0]       fg;
        logic [BG_W-1:0]        bg;
    } result_t;

    // atan(2^-i) in degrees, 16 fraction bits
    function automatic logic signed [Z_W-1:0] atan_q16(input logic [IDX_W-1:0] idx);
        logic signed [Z_W-1:0] a;
        unique case (idx)
            5'd0:    a = 24'sd2949120;
            5'd1:    a = 24'sd1740967;
            5'd2:    a = 24'sd919879;
            5'd3:    a = 24'sd466945;
            5'd4:    a = 24'sd234379;
            5'd5:    a = 24'sd117304;
            5'd6:    a = 24'sd58666;
            5'd7:    a = 24'sd29335;
            5'd8:    a = 24'sd14668;
            5'd9:    a = 24'sd7334;
            5'd10:   a = 24'sd3667;
            5'd11:   a = 24'sd1833;
            5'd12:   a = 24'sd917;
            5'd13:   a = 24'sd458;
            5'd14:   a = 24'sd229;
            5'd15:   a = 24'sd115;
            5'd16:   a = 24'sd57;
            5'd17:   a = 24'sd29;
            5'd18:   a = 24'sd14;
            5'd19:   a = 24'sd7;
            5'd20:   a = 24'sd4;
            5'd21:   a = 24'sd2;
            5'd22:   a = 24'sd1;
            default: a = '0;
        endcase
        return a;
    endfunction

endpackage

FILE: sv/turtle_vector_command_step.sv
`timescale 1ns / 1ps
// A result is registered on m_tdata after the front stages, the CORDIC cell chain, and the
// multiply, rounding and output registers. Throughput: one command per cycle while s_tready is high, set by the
// registered CORDIC cell chain; heading and position each close their feedback within their own register.
// s_tready drops only while the output skid register holds a beat.
// Reset (aresetn low, synchronous): pipeline emptied, heading 0, position 0,
// foreground 7, background 0, pattern '+'.

module turtle_vector_command_step (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // amount, colour, pattern_char, zero fill
    input  logic [tvcs_pkg::S_DATA_W-1:0]    s_tdata,
    // mode
    input  logic [tvcs_pkg::MODE_W-1:0]      s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // start_x, start_y, end_x, end_y, plot_char, fg_now, bg_now, zero fill
    output logic [tvcs_pkg::M_DATA_W-1:0]    m_tdata,
    // status
    output logic [tvcs_pkg::STAT_W-1:0]      m_tuser
);

    logic                en;
    tvcs_pkg::stage_t    chain [0:tvcs_pkg::CORDIC_STAGES];
    tvcs_pkg::result_t   res;

    assign s_tready = en;

    tvcs_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_tvalid),
        .in_mode   (s_tuser),
        .in_amount (s_tdata[tvcs_pkg::AMT_W-1:0]),
        .in_colour (s_tdata[tvcs_pkg::AMT_W +: tvcs_pkg::COL_W]),
        .in_pchar  (s_tdata[tvcs_pkg::AMT_W + tvcs_pkg::COL_W +: tvcs_pkg::CHAR_W]),
        .out_stage (chain[0])
    );

    for (genvar g = 0; g < tvcs_pkg::CORDIC_STAGES; g++) begin : g_cell
        tvcs_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .stage_idx (tvcs_pkg::IDX_W'(g)),
            .in_stage  (chain[g]),
            .out_stage (chain[g+1])
        );
    end

    tvcs_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_stage  (chain[tvcs_pkg::CORDIC_STAGES]),
        .out_ready (m_tready),
        .en        (en),
        .out_valid (m_tvalid),
        .out_res   (res)
    );

    assign m_tdata = tvcs_pkg::M_DATA_W'({res.bg, res.fg, res.pchar,
                                          res.ey, res.ex, res.sy, res.sx});
    assign m_tuser = res.status;

endmodule

FILE: sv/tvcs_front.sv
`timescale 1ns / 1ps

module tvcs_front (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 en,
    input  logic                                 in_valid,
    input  logic [tvcs_pkg::MODE_W-1:0]          in_mode,
    input  logic signed [tvcs_pkg::AMT_W-1:0]    in_amount,
    input  logic [tvcs_pkg::COL_W-1:0]           in_colour,
    input  logic [tvcs_pkg::CHAR_W-1:0]          in_pchar,
    output tvcs_pkg::stage_t                     out_stage
);

    // stage 1: offset amount and estimate the turn count
    logic signed [tvcs_pkg::U_W:0]                      u_wide;
    logic [tvcs_pkg::U_W-1:0]                           u_next;
    logic [tvcs_pkg::V_W-1:0]                           v_val;
    logic [tvcs_pkg::V_W+tvcs_pkg::RECIP_W-1:0]         q_prod;
    logic [tvcs_pkg::Q_W-1:0]                           q_next;
    tvcs_pkg::cmd_t                                     cmd_next;

    logic                                               s1_valid_reg;
    tvcs_pkg::cmd_t                                     s1_cmd_reg;
    logic [tvcs_pkg::U_W-1:0]                           s1_u_reg;
    logic [tvcs_pkg::Q_W-1:0]                           s1_q_reg;

    // stage 2: remainder in [0, 360)
    logic [tvcs_pkg::U_W-1:0]                           q_full;
    logic [tvcs_pkg::HEAD_W-1:0]                        r_next;
    logic                                               s2_valid_reg;
    tvcs_pkg::cmd_t                                     s2_cmd_reg;
    logic [tvcs_pkg::HEAD_W-1:0]                        s2_r_reg;

    // stage 3: heading register, quadrant split
    logic [tvcs_pkg::HEAD_W-1:0]                        heading_reg;
    logic [tvcs_pkg::HEAD_W-1:0]                        heading_next;
    logic [tvcs_pkg::HEAD_W:0]                          h_sum;
    logic [tvcs_pkg::HEAD_W-1:0]                        h_wrap;
    logic [1:0]                                         quad;
    logic [tvcs_pkg::HEAD_W-1:0]                        rem;
    tvcs_pkg::stage_t                                   out_next;
    tvcs_pkg::stage_t                                   out_reg;

    assign u_wide = (tvcs_pkg::U_W + 1)'(in_amount)
                  + (tvcs_pkg::U_W + 1)'(tvcs_pkg::TURN_OFFSET);
    assign u_next = u_wide[tvcs_pkg::U_W-1:0];
    assign v_val  = u_next[tvcs_pkg::U_W-1:tvcs_pkg::V_SH];
    assign q_prod = (tvcs_pkg::V_W + tvcs_pkg::RECIP_W)'(v_val)
                  * (tvcs_pkg::V_W + tvcs_pkg::RECIP_W)'(tvcs_pkg::RECIP);
    assign q_next = q_prod[tvcs_pkg::RSH+tvcs_pkg::Q_W-1:tvcs_pkg::RSH];

    always_comb begin
        cmd_next        = '0;
        cmd_next.mode   = in_mode;
        cmd_next.amount = in_amount;
        cmd_next.colour = in_colour;
        cmd_next.pchar  = in_pchar;
    end

    assign q_full = tvcs_pkg::U_W'(s1_q_reg) * tvcs_pkg::U_W'(tvcs_pkg::FULL_TURN);
    assign r_next = tvcs_pkg::HEAD_W'(s1_u_reg - q_full);

    assign h_sum  = {1'b0, heading_reg} + {1'b0, s2_r_reg};
    assign h_wrap = (h_sum >= (tvcs_pkg::HEAD_W + 1)'(tvcs_pkg::FULL_TURN))
                  ? tvcs_pkg::HEAD_W'(h_sum - (tvcs_pkg::HEAD_W + 1)'(tvcs_pkg::FULL_TURN))
                  : h_sum[tvcs_pkg::HEAD_W-1:0];

    always_comb begin
        if (en && s2_valid_reg && s2_cmd_reg.mode == tvcs_pkg::MODE_ROTATE) begin
            heading_next = h_wrap;
        end else begin
            heading_next = heading_reg;
        end
    end

    always_comb begin
        priority if (heading_reg >= tvcs_pkg::HEAD_W'(3 * tvcs_pkg::QUARTER)) begin
            quad = 2'd3;
            rem  = heading_reg - tvcs_pkg::HEAD_W'(3 * tvcs_pkg::QUARTER);
        end else if (heading_reg >= tvcs_pkg::HEAD_W'(2 * tvcs_pkg::QUARTER)) begin
            quad = 2'd2;
            rem  = heading_reg - tvcs_pkg::HEAD_W'(2 * tvcs_pkg::QUARTER);
        end else if (heading_reg >= tvcs_pkg::HEAD_W'(tvcs_pkg::QUARTER)) begin
            quad = 2'd1;
            rem  = heading_reg - tvcs_pkg::HEAD_W'(tvcs_pkg::QUARTER);
        end else begin
            quad = 2'd0;
            rem  = heading_reg;
        end
    end

    always_comb begin
        out_next          = '0;
        out_next.valid    = s2_valid_reg;
        out_next.cmd      = s2_cmd_reg;
        out_next.cmd.quad = quad;
        out_next.x        = tvcs_pkg::CORDIC_GAIN;
        out_next.y        = '0;
        out_next.z        = tvcs_pkg::Z_W'(rem) << tvcs_pkg::ZSH;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            heading_reg  <= '0;
        end else begin
            heading_reg <= heading_next;
            if (en) begin
                s1_valid_reg <= in_valid;
                s2_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s1_cmd_reg <= cmd_next;
            s1_u_reg   <= u_next;
            s1_q_reg   <= q_next;
            s2_cmd_reg <= s1_cmd_reg;
            s2_r_reg   <= r_next;
        end
        if (!aresetn) begin
            out_reg.valid <= 1'b0;
        end else if (en) begin
            out_reg <= out_next;
        end
    end

    assign out_stage = out_reg;

    a_heading_range: assert property (@(posedge aclk) disable iff (!aresetn)
        heading_reg < tvcs_pkg::HEAD_W'(tvcs_pkg::FULL_TURN))
        else $error("heading left [0, 360)");

    a_turn_remainder: assert property (@(posedge aclk) disable iff (!aresetn)
        s2_valid_reg |-> s2_r_reg < tvcs_pkg::HEAD_W'(tvcs_pkg::FULL_TURN))
        else $error("turn remainder not reduced");

endmodule

FILE: sv/tvcs_cell.sv
`timescale 1ns / 1ps

module tvcs_cell (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          en,
    input  logic [tvcs_pkg::IDX_W-1:0]    stage_idx,
    input  tvcs_pkg::stage_t              in_stage,
    output tvcs_pkg::stage_t              out_stage
);

    logic signed [tvcs_pkg::XY_W-1:0] xs;
    logic signed [tvcs_pkg::XY_W-1:0] ys;
    logic signed [tvcs_pkg::Z_W-1:0]  angle;
    logic                             rot_pos;
    tvcs_pkg::stage_t                 stage_next;
    tvcs_pkg::stage_t                 stage_reg;

    assign xs      = in_stage.x >>> stage_idx;
    assign ys      = in_stage.y >>> stage_idx;
    assign angle   = tvcs_pkg::atan_q16(stage_idx);
    assign rot_pos = !in_stage.z[tvcs_pkg::Z_W-1];

    always_comb begin
        stage_next = in_stage;
        if (rot_pos) begin
            stage_next.x = in_stage.x - ys;
            stage_next.y = in_stage.y + xs;
            stage_next.z = in_stage.z - angle;
        end else begin
            stage_next.x = in_stage.x + ys;
            stage_next.y = in_stage.y - xs;
            stage_next.z = in_stage.z + angle;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_reg.valid <= 1'b0;
        end else if (en) begin
            stage_reg <= stage_next;
        end
    end

    assign out_stage = stage_reg;

endmodule

FILE: sv/tvcs_back.sv
`timescale 1ns / 1ps

module tvcs_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  tvcs_pkg::stage_t    in_stage,
    input  logic                out_ready,
    output logic                en,
    output logic                out_valid,
    output tvcs_pkg::result_t   out_res
);

    // multiply stage
    logic signed [tvcs_pkg::XY_W-1:0]   c_sel;
    logic signed [tvcs_pkg::XY_W-1:0]   s_sel;
    logic signed [tvcs_pkg::PROD_W-1:0] pc_next;
    logic signed [tvcs_pkg::PROD_W-1:0] ps_next;
    logic                               mul_valid_reg;
    tvcs_pkg::cmd_t                     mul_cmd_reg;
    logic signed [tvcs_pkg::PROD_W-1:0] mul_pc_reg;
    logic signed [tvcs_pkg::PROD_W-1:0] mul_ps_reg;

    // rounding stage
    logic signed [tvcs_pkg::PROD_W:0]   rc;
    logic signed [tvcs_pkg::PROD_W:0]   rs;
    logic signed [tvcs_pkg::DX_W-1:0]   dx_next;
    logic signed [tvcs_pkg::DX_W-1:0]   dy_next;
    logic                               rnd_valid_reg;
    tvcs_pkg::cmd_t                     rnd_cmd_reg;
    logic signed [tvcs_pkg::DX_W-1:0]   rnd_dx_reg;
    logic signed [tvcs_pkg::DX_W-1:0]   rnd_dy_reg;

    // turtle state
    logic signed [tvcs_pkg::POS_W-1:0]  pos_x_reg;
    logic signed [tvcs_pkg::POS_W-1:0]  pos_y_reg;
    logic signed [tvcs_pkg::POS_W-1:0]  pos_x_next;
    logic signed [tvcs_pkg::POS_W-1:0]  pos_y_next;
    logic [tvcs_pkg::COL_W-1:0]         fg_reg;
    logic [tvcs_pkg::COL_W-1:0]         fg_next;
    logic [tvcs_pkg::BG_W-1:0]          bg_reg;
    logic [tvcs_pkg::BG_W-1:0]          bg_next;
    logic [tvcs_pkg::CHAR_W-1:0]        pattern_reg;
    logic [tvcs_pkg::CHAR_W-1:0]        pattern_next;

    logic signed [tvcs_pkg::NX_W-1:0]   nx;
    logic signed [tvcs_pkg::NX_W-1:0]   ny;
    logic signed [tvcs_pkg::NX_W-1:0]   rx;
    logic signed [tvcs_pkg::NX_W-1:0]   ry;
    logic signed [tvcs_pkg::NX_W-1:0]   spx;
    logic signed [tvcs_pkg::NX_W-1:0]   spy;
    logic                               off_range;
    logic                               bad_len;
    logic                               fire;
    tvcs_pkg::result_t                  res;

    // output register plus skid
    logic                               out_valid_reg;
    logic                               out_valid_next;
    tvcs_pkg::result_t                  out_res_reg;
    tvcs_pkg::result_t                  out_res_next;
    logic                               skid_valid_reg;
    logic                               skid_valid_next;
    tvcs_pkg::result_t                  skid_res_reg;
    tvcs_pkg::result_t                  skid_res_next;

    assign en = !skid_valid_reg;

    // exact quadrant rotation
    always_comb begin
        unique case (in_stage.cmd.quad)
            2'd0: begin
                c_sel = in_stage.x;
                s_sel = in_stage.y;
            end
            2'd1: begin
                c_sel = -in_stage.y;
                s_sel = in_stage.x;
            end
            2'd2: begin
                c_sel = -in_stage.x;
                s_sel = -in_stage.y;
            end
            2'd3: begin
                c_sel = in_stage.y;
                s_sel = -in_stage.x;
            end
        endcase
    end

    assign pc_next = tvcs_pkg::PROD_W'(in_stage.cmd.amount) * tvcs_pkg::PROD_W'(c_sel);
    assign ps_next = tvcs_pkg::PROD_W'(in_stage.cmd.amount) * tvcs_pkg::PROD_W'(s_sel);

    assign rc      = (tvcs_pkg::PROD_W + 1)'(mul_pc_reg) + tvcs_pkg::HALF_Q30;
    assign rs      = -((tvcs_pkg::PROD_W + 1)'(mul_ps_reg)) + tvcs_pkg::HALF_Q30;
    assign dx_next = tvcs_pkg::DX_W'(rc >>> tvcs_pkg::CS_FRAC);
    assign dy_next = tvcs_pkg::DX_W'(rs >>> tvcs_pkg::CS_FRAC);

    assign nx  = tvcs_pkg::NX_W'(pos_x_reg) + tvcs_pkg::NX_W'(rnd_dx_reg);
    assign ny  = tvcs_pkg::NX_W'(pos_y_reg) + tvcs_pkg::NX_W'(rnd_dy_reg);
    assign rx  = nx + tvcs_pkg::HALF_PIX;
    assign ry  = ny + tvcs_pkg::HALF_PIX;
    assign spx = tvcs_pkg::NX_W'(pos_x_reg) + tvcs_pkg::HALF_PIX;
    assign spy = tvcs_pkg::NX_W'(pos_y_reg) + tvcs_pkg::HALF_PIX;

    // sign bit and any bit above the coordinate range both mean off screen
    assign off_range = (rx[tvcs_pkg::NX_W-1:tvcs_pkg::COORD_HI] != '0)
                    || (ry[tvcs_pkg::NX_W-1:tvcs_pkg::COORD_HI] != '0);
    assign bad_len   = rnd_cmd_reg.amount[tvcs_pkg::AMT_W-1] || (rnd_cmd_reg.amount == '0);
    assign fire      = en && rnd_valid_reg;

    always_comb begin
        pos_x_next   = pos_x_reg;
        pos_y_next   = pos_y_reg;
        fg_next      = fg_reg;
        bg_next      = bg_reg;
        pattern_next = pattern_reg;
        res          = '0;
        res.status   = tvcs_pkg::ST_UPDATED;
        if (fire) begin
            unique case (rnd_cmd_reg.mode)
                tvcs_pkg::MODE_ROTATE: begin
                end
                tvcs_pkg::MODE_MOVE, tvcs_pkg::MODE_DRAW: begin
                    priority if (bad_len) begin
                        res.status = tvcs_pkg::ST_BAD_LENGTH;
                    end else if (off_range) begin
                        res.status = tvcs_pkg::ST_OFF_RANGE;
                    end else begin
                        res.status = tvcs_pkg::ST_SEGMENT;
                        res.sx = spx[tvcs_pkg::NX_W-1] ? '0
                               : spx[tvcs_pkg::COORD_HI-1:tvcs_pkg::FRAC_BITS];
                        res.sy = spy[tvcs_pkg::NX_W-1] ? '0
                               : spy[tvcs_pkg::COORD_HI-1:tvcs_pkg::FRAC_BITS];
                        res.ex = rx[tvcs_pkg::COORD_HI-1:tvcs_pkg::FRAC_BITS];
                        res.ey = ry[tvcs_pkg::COORD_HI-1:tvcs_pkg::FRAC_BITS];
                        res.pchar = (rnd_cmd_reg.mode == tvcs_pkg::MODE_MOVE)
                                  ? tvcs_pkg::CHAR_SPACE : pattern_reg;
                        pos_x_next = nx[tvcs_pkg::POS_W-1:0];
                        pos_y_next = ny[tvcs_pkg::POS_W-1:0];
                    end
                end
                tvcs_pkg::MODE_FG: begin
                    if (rnd_cmd_reg.colour != '0) begin
                        fg_next = rnd_cmd_reg.colour;
                    end else begin
                        res.status = tvcs_pkg::ST_BAD_COLOUR;
                    end
                end
                tvcs_pkg::MODE_BG: begin
                    if (!rnd_cmd_reg.colour[tvcs_pkg::COL_W-1] && rnd_cmd_reg.colour != '0) begin
                        bg_next = rnd_cmd_reg.colour[tvcs_pkg::BG_W-1:0];
                    end else begin
                        res.status = tvcs_pkg::ST_BAD_COLOUR;
                    end
                end
                tvcs_pkg::MODE_PATTERN: begin
                    pattern_next = rnd_cmd_reg.pchar;
                end
                default: begin
                end
            endcase
        end
        res.fg = fg_next;
        res.bg = bg_next;
    end

    always_comb begin
        out_valid_next  = out_valid_reg;
        out_res_next    = out_res_reg;
        skid_valid_next = skid_valid_reg;
        skid_res_next   = skid_res_reg;
        priority if (skid_valid_reg && out_ready) begin
            out_res_next    = skid_res_reg;
            skid_valid_next = 1'b0;
        end else if (fire) begin
            if (!out_valid_reg || out_ready) begin
                out_valid_next = 1'b1;
                out_res_next   = res;
            end else begin
                skid_valid_next = 1'b1;
                skid_res_next   = res;
            end
        end else if (out_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mul_valid_reg  <= 1'b0;
            rnd_valid_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
            pos_x_reg      <= '0;
            pos_y_reg      <= '0;
            fg_reg         <= tvcs_pkg::RESET_FG;
            bg_reg         <= tvcs_pkg::RESET_BG;
            pattern_reg    <= tvcs_pkg::RESET_PATTERN;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
            pos_x_reg      <= pos_x_next;
            pos_y_reg      <= pos_y_next;
            fg_reg         <= fg_next;
            bg_reg         <= bg_next;
            pattern_reg    <= pattern_next;
            if (en) begin
                mul_valid_reg <= in_stage.valid;
                rnd_valid_reg <= mul_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        out_res_reg  <= out_res_next;
        skid_res_reg <= skid_res_next;
        if (en) begin
            mul_cmd_reg <= in_stage.cmd;
            mul_pc_reg  <= pc_next;
            mul_ps_reg  <= ps_next;
            rnd_cmd_reg <= mul_cmd_reg;
            rnd_dx_reg  <= dx_next;
            rnd_dy_reg  <= dy_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_res   = out_res_reg;

    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid holds a beat while the output register is empty");

    a_no_segment_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_res_reg.status != tvcs_pkg::ST_SEGMENT)
        |-> (out_res_reg.sx == '0 && out_res_reg.sy == '0 && out_res_reg.ex == '0
             && out_res_reg.ey == '0 && out_res_reg.pchar == '0))
        else $error("non-segment result carries coordinates");

    a_pos_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && res.status != tvcs_pkg::ST_SEGMENT)
        |=> ($stable(pos_x_reg) && $stable(pos_y_reg)))
        else $error("position moved without a segment");

endmodule
